// File: sv/dsb_pkg.sv
package dsb_pkg;

    localparam int CHANNEL_COUNT_DEF = 4;
    localparam int MAX_DELAY_DEF     = 255;
    localparam int MAX_CHANNELS      = 4;

    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 16;
    localparam int DELAY_W    = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_BITS  = 12;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(4096);
    localparam logic [DELAY_W-1:0]  DELAY_RESET  = '0;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_CH0,
        CFG_WEIGHT_CH1,
        CFG_WEIGHT_CH2,
        CFG_WEIGHT_CH3,
        CFG_DELAY_CH0,
        CFG_DELAY_CH1,
        CFG_DELAY_CH2,
        CFG_DELAY_CH3
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_ch0;
        logic signed [SAMPLE_W-1:0] sample_ch1;
        logic signed [SAMPLE_W-1:0] sample_ch2;
        logic signed [SAMPLE_W-1:0] sample_ch3;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic                       overflow;
    } out_item_t;

    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

endpackage

// File: sv/dsb_ram.sv
module dsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/dsb_front.sv
module dsb_front import dsb_pkg::*; #(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int MAX_DELAY     = MAX_DELAY_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  in_item_t                             s_data,
    input  logic [MAX_CHANNELS-1:0][DELAY_W-1:0] delays,
    input  q_status_t                            q_status,
    output logic                                 push_valid,
    output logic [CHANNEL_COUNT*SAMPLE_W-1:0]    push_data
);

    localparam int LINE_LEN = MAX_DELAY + 1;
    localparam int ADDR_W   = $clog2(LINE_LEN);

    logic                              accept;
    logic [Q_CNT_W:0]                  slots_used;
    logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] in_arr;

    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic              f1_valid_reg, f1_valid_next;

    logic [ADDR_W-1:0]   d_clamp  [CHANNEL_COUNT];
    logic [ADDR_W-1:0]   rd_addr  [CHANNEL_COUNT];
    logic [SAMPLE_W-1:0] line_q   [CHANNEL_COUNT];

    logic [CHANNEL_COUNT-1:0] f1_cur_reg;
    logic [CHANNEL_COUNT-1:0] f1_zero_reg;
    logic [SAMPLE_W-1:0]      f1_sample_reg [CHANNEL_COUNT];

    always_comb begin
        in_arr[0] = s_data.sample_ch0;
        in_arr[1] = s_data.sample_ch1;
        in_arr[2] = s_data.sample_ch2;
        in_arr[3] = s_data.sample_ch3;
    end

    // An item in the read stage already owns a queue slot, so it counts against the space.
    assign slots_used = {1'b0, q_status.count} + {{Q_CNT_W{1'b0}}, f1_valid_reg};
    assign s_ready    = slots_used < (Q_CNT_W + 1)'(QUEUE_DEPTH);
    assign accept     = s_valid && s_ready;

    always_comb begin
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (int'(delays[c]) > MAX_DELAY) begin
                d_clamp[c] = ADDR_W'(MAX_DELAY);
            end else begin
                d_clamp[c] = ADDR_W'(delays[c]);
            end
            if (wp_reg >= d_clamp[c]) begin
                rd_addr[c] = wp_reg - d_clamp[c];
            end else begin
                rd_addr[c] = ADDR_W'({1'b0, wp_reg} + (ADDR_W + 1)'(LINE_LEN)
                                     - {1'b0, d_clamp[c]});
            end
        end
    end

    for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_line
        dsb_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (LINE_LEN)
        ) u_line (
            .clk   (aclk),
            .we    (accept),
            .waddr (wp_reg),
            .wdata (in_arr[g]),
            .raddr (rd_addr[g]),
            .rdata (line_q[g])
        );
    end

    always_comb begin
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        f1_valid_next = accept;
        if (accept) begin
            wp_next = (int'(wp_reg) == MAX_DELAY) ? '0 : wp_reg + 1'b1;
            if (int'(fill_reg) != MAX_DELAY) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            fill_reg     <= '0;
            f1_valid_reg <= 1'b0;
        end else begin
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            f1_valid_reg <= f1_valid_next;
        end
    end

    // A delay reaching past the frames written so far lands on an entry never written,
    // which stands for the silence the line held after reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                f1_cur_reg[c]    <= (d_clamp[c] == '0);
                f1_zero_reg[c]   <= (d_clamp[c] > fill_reg);
                f1_sample_reg[c] <= in_arr[c];
            end
        end
    end

    assign push_valid = f1_valid_reg;

    always_comb begin
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (f1_cur_reg[c]) begin
                push_data[c*SAMPLE_W +: SAMPLE_W] = f1_sample_reg[c];
            end else if (f1_zero_reg[c]) begin
                push_data[c*SAMPLE_W +: SAMPLE_W] = '0;
            end else begin
                push_data[c*SAMPLE_W +: SAMPLE_W] = line_q[c];
            end
        end
    end

endmodule

// File: sv/dsb_queue.sv
module dsb_queue import dsb_pkg::*; #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_status_t        q_status
);

    logic [WIDTH-1:0]   entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data       = entry_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.count = count_reg;

endmodule

// File: sv/dsb_back.sv
module dsb_back import dsb_pkg::*; #(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  q_status_t                             q_status,
    input  logic [CHANNEL_COUNT*SAMPLE_W-1:0]     pop_data,
    output logic                                  pop,
    input  logic [MAX_CHANNELS-1:0][WEIGHT_W-1:0] weights,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output out_item_t                             m_data
);

    localparam int PROD_W = SAMPLE_W + WEIGHT_W;
    localparam int SUM_W  = PROD_W + $clog2(CHANNEL_COUNT);
    localparam int Y_W    = SUM_W - FRAC_BITS;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [Y_W-1:0]   Y_MAX      = Y_W'(SAMPLE_MAX);
    localparam logic signed [Y_W-1:0]   Y_MIN      = Y_W'(SAMPLE_MIN);

    logic advance;

    logic signed [PROD_W-1:0] prod_reg [CHANNEL_COUNT];
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]  rounded;
    logic signed [Y_W-1:0]    y_floor;
    out_item_t                out_reg, out_next;

    logic prod_valid_reg, prod_valid_next;
    logic sum_valid_reg, sum_valid_next;
    logic out_valid_reg, out_valid_next;

    // The whole pipeline moves together and freezes while the output item waits.
    assign advance = !out_valid_reg || m_ready;
    assign pop     = advance && !q_status.empty;

    always_comb begin
        sum_next = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            sum_next = sum_next + SUM_W'(prod_reg[c]);
        end
    end

    // Adding half and dropping the fraction rounds ties upward.
    always_comb begin
        rounded  = sum_reg + ROUND_HALF;
        y_floor  = $signed(rounded[SUM_W-1:FRAC_BITS]);
        out_next = '0;
        if (y_floor > Y_MAX) begin
            out_next.mixed_sample = SAMPLE_W'(SAMPLE_MAX);
            out_next.overflow     = 1'b1;
        end else if (y_floor < Y_MIN) begin
            out_next.mixed_sample = SAMPLE_W'(SAMPLE_MIN);
            out_next.overflow     = 1'b1;
        end else begin
            out_next.mixed_sample = y_floor[SAMPLE_W-1:0];
            out_next.overflow     = 1'b0;
        end
    end

    always_comb begin
        prod_valid_next = prod_valid_reg;
        sum_valid_next  = sum_valid_reg;
        out_valid_next  = out_valid_reg;
        if (advance) begin
            prod_valid_next = pop;
            sum_valid_next  = prod_valid_reg;
            out_valid_next  = sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            sum_valid_reg  <= sum_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                prod_reg[c] <= $signed(weights[c]) * $signed(pop_data[c*SAMPLE_W +: SAMPLE_W]);
            end
            sum_reg <= sum_next;
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: sv/delay_and_sum_beamformer_unit.sv
// Path: a result is offered once its item has passed the line read, queue, multiply, sum,
// and round and saturate stages, and waits longer only while the output is stalled.
// Throughput: one item per cycle while the queue has room; the four-entry queue between the
// delay lines and the multiply-accumulate pipeline sets how many items may wait in a stall.
// Reset: weights return to unity and delays to zero; a fill count makes every delay line
// read as silence until written, so there is no clearing pass and items are taken at once.
module delay_and_sum_beamformer_unit import dsb_pkg::*; #(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int MAX_DELAY     = MAX_DELAY_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [MAX_CHANNELS-1:0][WEIGHT_W-1:0] weight_reg, weight_next;
    logic [MAX_CHANNELS-1:0][DELAY_W-1:0]  delay_reg, delay_next;

    logic                              push_valid;
    logic [CHANNEL_COUNT*SAMPLE_W-1:0] push_data;
    logic                              pop;
    logic [CHANNEL_COUNT*SAMPLE_W-1:0] pop_data;
    q_status_t                         q_status;

    always_comb begin
        weight_next = weight_reg;
        delay_next  = delay_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_WEIGHT_CH0: weight_next[0] = cfg_wdata[WEIGHT_W-1:0];
                CFG_WEIGHT_CH1: weight_next[1] = cfg_wdata[WEIGHT_W-1:0];
                CFG_WEIGHT_CH2: weight_next[2] = cfg_wdata[WEIGHT_W-1:0];
                CFG_WEIGHT_CH3: weight_next[3] = cfg_wdata[WEIGHT_W-1:0];
                CFG_DELAY_CH0:  delay_next[0]  = cfg_wdata[DELAY_W-1:0];
                CFG_DELAY_CH1:  delay_next[1]  = cfg_wdata[DELAY_W-1:0];
                CFG_DELAY_CH2:  delay_next[2]  = cfg_wdata[DELAY_W-1:0];
                CFG_DELAY_CH3:  delay_next[3]  = cfg_wdata[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                weight_reg[c] <= WEIGHT_RESET;
                delay_reg[c]  <= DELAY_RESET;
            end
        end else begin
            weight_reg <= weight_next;
            delay_reg  <= delay_next;
        end
    end

    dsb_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .MAX_DELAY     (MAX_DELAY)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .delays     (delay_reg),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    dsb_queue #(
        .WIDTH (CHANNEL_COUNT * SAMPLE_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    dsb_back #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .weights  (weight_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (q_status.count != Q_CNT_W'(QUEUE_DEPTH)))
        else $error("item pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("item popped from an empty queue");

    a_accept_reaches_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> push_valid)
        else $error("accepted item did not reach the queue");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
